// ===== hdl/morphology_3x3_erode_dilate_core_macros.svh =====
// ----------------------------------------------------------------------------
// morphology_3x3_erode_dilate_core_macros.svh
// Assertion macros used by the checker file of the morphology core.
// ----------------------------------------------------------------------------
`ifndef MORPHOLOGY_3X3_ERODE_DILATE_CORE_MACROS_SVH
`define MORPHOLOGY_3X3_ERODE_DILATE_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define M3ED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("m3ed: same-cycle check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define M3ED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("m3ed: next-cycle check failed");

`endif

// ===== hdl/m3ed_pkg.sv =====
// ----------------------------------------------------------------------------
// m3ed_pkg
// Types, constants and helpers shared by the 3x3 morphology core.
// ----------------------------------------------------------------------------
`default_nettype none

package m3ed_pkg;

    // pixel and configuration widths
    localparam int PIX_W  = 8;
    localparam int CFG_DW = 11;
    localparam int CFG_IW = 3;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_DO_DILATE    = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] REG_FULL_SQUARE  = CFG_IW'(3);
    localparam logic [CFG_IW-1:0] REG_BINARY_IMAGE = CFG_IW'(4);

    // reset geometry
    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    // input word opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // padding levels for cells outside the frame
    localparam logic [PIX_W-1:0] PAD_DILATE    = PIX_W'(0);
    localparam logic [PIX_W-1:0] PAD_ERODE     = PIX_W'(255);
    localparam logic [PIX_W-1:0] PAD_ERODE_BIN = PIX_W'(1);

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // operating mode bits
    typedef struct packed {
        logic dilate;
        logic full;
        logic binary;
    } t_mode;

    // how the back end must treat one column word
    typedef struct packed {
        logic emit;      // a result is due with this word
        logic first;     // word is column 0: centre is the last column of a row
        logic left_ok;
        logic right_ok;
        logic top_ok;
        logic bot_ok;
        logic last;      // final result of the frame
    } t_cls;

    // one column of three pixels plus its classification
    typedef struct packed {
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] lo;
        t_cls             cls;
    } t_item;

    // minimum for erosion, maximum for dilation
    function automatic logic [PIX_W-1:0] f_pick(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic             dilate);
        logic a_gt;
        a_gt = a > b;
        f_pick = (a_gt == dilate) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/m3ed_front.sv =====
// ----------------------------------------------------------------------------
// m3ed_front
// Accepts input words, tracks the raster position, classifies each word and
// runs the two-row line store. Emits one column word per pushed word.
// ----------------------------------------------------------------------------
`default_nettype none

module m3ed_front import m3ed_pkg::*; #(
    parameter int  MAX_WIDTH  = 1024,
    parameter int  MAX_HEIGHT = 1024,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int RW         = $clog2(MAX_HEIGHT + 2)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_restart,
    input  wire logic [CW-1:0]    i_w_last,
    input  wire logic             i_w_ge2,
    input  wire logic [RW-1:0]    i_h,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_opcode,
    input  wire logic [PIX_W-1:0] i_pixel,
    input  wire logic [Q_CW-1:0]  i_q_count,
    output logic                  o_push,
    output t_item                 o_item
);

    // raster position of the next word
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // read stage
    logic                 r_s1_valid;
    logic [CW-1:0]        r_s1_col;
    logic [PIX_W-1:0]     r_s1_cur;
    t_cls                 r_s1_cls;
    logic                 r_s1_byp;
    logic [2*PIX_W-1:0]   r_fwd;
    logic [2*PIX_W-1:0]   r_rd;

    // line store: {upper, middle} per column
    logic [2*PIX_W-1:0]   mem [MAX_WIDTH];

    logic [Q_CW:0]        fill;
    logic                 in_frame;
    logic                 col_first;
    logic                 win_ready;
    logic                 push;
    logic [PIX_W-1:0]     cur;
    logic                 n_byp;
    t_cls                 n_cls;
    logic [2*PIX_W-1:0]   rd;
    logic [2*PIX_W-1:0]   wdata;

    // room in queue for the word in flight and this one
    assign fill    = {1'b0, i_q_count} + (Q_CW+1)'(r_s1_valid);
    assign o_ready = fill < (Q_CW+1)'(Q_DEPTH);

    // classify the word at the current position
    assign in_frame  = r_row < i_h;
    assign col_first = r_col == '0;
    assign win_ready = (r_row >= RW'(2)) || ((r_row == RW'(1)) && !col_first);
    assign push      = i_valid && o_ready && !((i_opcode == OP_DRAIN) && in_frame);
    assign cur       = in_frame ? i_pixel : '0;
    assign n_byp     = r_s1_valid && (r_col == r_s1_col);

    always_comb begin
        n_cls.emit     = win_ready;
        n_cls.first    = col_first;
        n_cls.right_ok = !col_first;
        if (col_first) begin
            n_cls.left_ok = i_w_ge2;
            n_cls.top_ok  = r_row >= RW'(3);
            n_cls.bot_ok  = r_row <= i_h;
            n_cls.last    = win_ready && (r_row == i_h + RW'(1));
        end else begin
            n_cls.left_ok = r_col >= CW'(2);
            n_cls.top_ok  = r_row >= RW'(2);
            n_cls.bot_ok  = r_row < i_h;
            n_cls.last    = 1'b0;
        end
    end

    // position update; frame restarts after its last result
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (push) begin
            if (r_col == i_w_last) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
            if (n_cls.last) begin
                n_col = '0;
                n_row = '0;
            end
        end
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_s1_col <= r_col;
            r_s1_cur <= cur;
            r_s1_cls <= n_cls;
            r_s1_byp <= n_byp;
        end
        r_fwd <= wdata;
    end

    // store read data, forwarded when the previous word wrote the same column
    assign rd    = r_s1_byp ? r_fwd : r_rd;
    assign wdata = {rd[PIX_W-1:0], r_s1_cur};

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_rd <= mem[r_col];
        end
        if (r_s1_valid) begin
            mem[r_s1_col] <= wdata;
        end
    end

    // column word to the queue
    assign o_push     = r_s1_valid;
    assign o_item.up  = rd[2*PIX_W-1:PIX_W];
    assign o_item.mid = rd[PIX_W-1:0];
    assign o_item.lo  = r_s1_cur;
    assign o_item.cls = r_s1_cls;

endmodule

`default_nettype wire

// ===== hdl/m3ed_fifo.sv =====
// ----------------------------------------------------------------------------
// m3ed_fifo
// Short queue of column words between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module m3ed_fifo import m3ed_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  t_item                i_item,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output t_item                o_head,
    output logic [Q_CW-1:0]      o_count
);

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_CW-1:0]   r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== hdl/m3ed_back.sv =====
// ----------------------------------------------------------------------------
// m3ed_back
// Holds the left and centre window columns, combines them with the incoming
// column into the min or max over the window, and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module m3ed_back import m3ed_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  t_mode                 i_mode,
    input  wire logic             i_q_valid,
    input  t_item                 i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [PIX_W-1:0]      o_pixel,
    output logic                  o_last
);

    // window columns: left and centre
    logic [PIX_W-1:0] r_l_up, r_l_mid, r_l_lo;
    logic [PIX_W-1:0] r_c_up, r_c_mid, r_c_lo;

    // result word
    logic             r_o_valid;
    logic [PIX_W-1:0] r_o_pixel;
    logic             r_o_last;

    logic [PIX_W-1:0] pad;
    logic [PIX_W-1:0] up, dn, lf, rt, ul, ur, dl, dr;
    logic [PIX_W-1:0] cross_v, corner_v, result;
    logic             dil;
    t_cls             cls;

    assign dil = i_mode.dilate;
    assign cls = i_head.cls;
    assign pad = dil ? PAD_DILATE : (i_mode.binary ? PAD_ERODE_BIN : PAD_ERODE);

    // take the head word unless its result has nowhere to go
    assign o_pop = i_q_valid && (!cls.emit || !r_o_valid || i_ready);

    // padded neighbours; the incoming column is the right one
    always_comb begin
        up = cls.top_ok ? r_c_up : pad;
        dn = cls.bot_ok ? r_c_lo : pad;
        lf = cls.left_ok ? r_l_mid : pad;
        rt = cls.right_ok ? i_head.mid : pad;
        ul = (cls.left_ok && cls.top_ok) ? r_l_up : pad;
        dl = (cls.left_ok && cls.bot_ok) ? r_l_lo : pad;
        ur = (cls.right_ok && cls.top_ok) ? i_head.up : pad;
        dr = (cls.right_ok && cls.bot_ok) ? i_head.lo : pad;
    end

    // min/max tree
    always_comb begin
        cross_v  = f_pick(r_c_mid, f_pick(f_pick(lf, rt, dil), f_pick(up, dn, dil), dil), dil);
        corner_v = f_pick(f_pick(ul, dr, dil), f_pick(ur, dl, dil), dil);
        result   = i_mode.full ? f_pick(cross_v, corner_v, dil) : cross_v;
    end

    // window shift
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_l_up  <= r_c_up;
            r_l_mid <= r_c_mid;
            r_l_lo  <= r_c_lo;
            r_c_up  <= i_head.up;
            r_c_mid <= i_head.mid;
            r_c_lo  <= i_head.lo;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_pop && cls.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && cls.emit) begin
            r_o_pixel <= result;
            r_o_last  <= cls.last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_pixel = r_o_pixel;
    assign o_last  = r_o_last;

endmodule

`default_nettype wire

// ===== hdl/morphology_3x3_erode_dilate_core.sv =====
// ----------------------------------------------------------------------------
// morphology_3x3_erode_dilate_core
// 3x3 grayscale erosion / dilation over a raster pixel stream, cross or
// full-square window, with configurable frame size and padding.
// ----------------------------------------------------------------------------
// Takes one word per clock and gives one result per clock, sustained; the
// input stalls only while a finished result is held off by the output side.
// Result p leaves after input word p+W+1 (W = frame width) is taken, passing
// through the line store read stage, the queue and the output register. The
// line store is a single MAX_WIDTH x 16 memory read at one column and written
// back at the next clock, so it sets the one word per clock figure. After the
// last pixel of a frame send W+1 drain words; the final result carries
// frame_last. A write to a known register index restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module morphology_3x3_erode_dilate_core import m3ed_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // pixel input
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_opcode,
    input  wire logic [PIX_W-1:0]  i_pixel_value,
    // result output
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [PIX_W-1:0]       o_result_pixel,
    output logic                   o_frame_last,
    // configuration writes
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int EWW   = ((CFG_DW > $clog2(MAX_WIDTH + 1)) ?
                            CFG_DW : $clog2(MAX_WIDTH + 1)) + 1;
    localparam int EWH   = ((CFG_DW > $clog2(MAX_HEIGHT + 1)) ?
                            CFG_DW : $clog2(MAX_HEIGHT + 1)) + 1;
    localparam int W_RST = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int H_RST = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

    // configuration state, geometry kept in effective form
    logic [CW-1:0]  r_w_last;
    logic           r_w_ge2;
    logic [RW-1:0]  r_h;
    t_mode          r_mode;

    logic [EWW-1:0] w_eff;
    logic [EWH-1:0] h_eff;
    logic           restart;

    t_item           f_item;
    logic            f_push;
    t_item           q_head;
    logic            q_valid;
    logic [Q_CW-1:0] q_count;
    logic            b_pop;

    assign o_cfg_ready = 1'b1;

    // clamp written width and height into the supported range
    always_comb begin
        if (i_cfg_data == '0) begin
            w_eff = EWW'(1);
        end else if (EWW'(i_cfg_data) > EWW'(MAX_WIDTH)) begin
            w_eff = EWW'(MAX_WIDTH);
        end else begin
            w_eff = EWW'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            h_eff = EWH'(1);
        end else if (EWH'(i_cfg_data) > EWH'(MAX_HEIGHT)) begin
            h_eff = EWH'(MAX_HEIGHT);
        end else begin
            h_eff = EWH'(i_cfg_data);
        end
    end

    // any known register write restarts the frame
    always_comb begin
        restart = i_cfg_valid &&
                  (i_cfg_index inside {[REG_FRAME_WIDTH:REG_BINARY_IMAGE]});
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(W_RST - 1);
            r_w_ge2  <= (W_RST >= 2);
            r_h      <= RW'(H_RST);
            r_mode   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH: begin
                    r_w_last <= CW'(w_eff - EWW'(1));
                    r_w_ge2  <= w_eff >= EWW'(2);
                end
                REG_FRAME_HEIGHT: r_h           <= RW'(h_eff);
                REG_DO_DILATE:    r_mode.dilate <= i_cfg_data[0];
                REG_FULL_SQUARE:  r_mode.full   <= i_cfg_data[0];
                REG_BINARY_IMAGE: r_mode.binary <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    m3ed_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_w_last  (r_w_last),
        .i_w_ge2   (r_w_ge2),
        .i_h       (r_h),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_opcode  (i_opcode),
        .i_pixel   (i_pixel_value),
        .i_q_count (q_count),
        .o_push    (f_push),
        .o_item    (f_item)
    );

    m3ed_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_count (q_count)
    );

    m3ed_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (b_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_pixel   (o_result_pixel),
        .o_last    (o_frame_last)
    );

endmodule

`default_nettype wire

// ===== hdl/m3ed_checker.sv =====
// ----------------------------------------------------------------------------
// m3ed_checker
// Port-level checks on the morphology core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "morphology_3x3_erode_dilate_core_macros.svh"

module m3ed_checker import m3ed_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [PIX_W-1:0] o_result_pixel,
    input wire logic             o_frame_last
);

    // a held result word keeps its value
    `M3ED_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_result_pixel) && $stable(o_frame_last))

    // no result word straight out of reset
    `M3ED_ASSERT_NOW(a_out_empty_after_reset, $rose(i_rst_n), !o_out_valid)

    // input back-pressure only follows a held-off result
    `M3ED_ASSERT_NOW(a_stall_cause, !o_in_ready, $past(o_out_valid && !i_out_ready))

endmodule

bind morphology_3x3_erode_dilate_core m3ed_checker u_m3ed_checker (.*);

`default_nettype wire

// ===== tb/morphology_3x3_erode_dilate_core_test.sv =====
// ----------------------------------------------------------------------------
// morphology_3x3_erode_dilate_core_test
// Self-checking bench for the 3x3 erosion / dilation core. A scoreboard
// object mirrors the line stores, window and frame counters. It predicts
// each output word from the accepted pixel words and compares it field by
// field. The stimulus runs a short hand-made part and then random frames of
// random geometry and mode, with idle phases, back-pressure, aborted frames
// and writes to unused register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module morphology_3x3_erode_dilate_core_test;
    import m3ed_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 150;
    localparam int RANDOM_ITEMS  = 1350;

    // indexes past the register list, writes there are dropped
    localparam logic [CFG_IW-1:0] REG_SPARE_FIRST = CFG_IW'(5);
    localparam logic [CFG_IW-1:0] REG_SPARE_LAST  = CFG_IW'(7);

    typedef enum int {
        STYLE_UNIFORM,
        STYLE_BINARY,
        STYLE_HOLES,
        STYLE_SPOTS
    } pixel_style_t;

    typedef struct {
        logic [PIX_W-1:0] result_pixel;
        logic             frame_last;
    } frame_result_t;

    // ------------------------------------------------------------------
    // scoreboard: window predictor plus queue of expected output words
    // ------------------------------------------------------------------
    class morph_checker;
        logic [CFG_DW-1:0] width_reg;
        logic [CFG_DW-1:0] height_reg;
        logic              dilate_reg;
        logic              full_reg;
        logic              binary_reg;
        logic [PIX_W-1:0]  upper_line [MAX_W];
        logic [PIX_W-1:0]  middle_line [MAX_W];
        logic [PIX_W-1:0]  win [3][3];      // [column][row: upper, middle, lower]
        int                col_pos;
        int                row_pos;
        int                out_pos;
        frame_result_t     expected_results[$];
        int                errors;

        function new();
            width_reg  = CFG_DW'(RST_WIDTH);
            height_reg = CFG_DW'(RST_HEIGHT);
            dilate_reg = 1'b0;
            full_reg   = 1'b0;
            binary_reg = 1'b0;
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            errors = 0;
            restart();
        endfunction

        function void restart();
            col_pos = 0;
            row_pos = 0;
            out_pos = 0;
            foreach (win[c, r]) win[c][r] = '0;
        endfunction

        // zero acts as one, oversize clamps to the store size
        function int frame_cols();
            int v;
            v = int'(width_reg);
            if (v == 0) v = 1;
            else if (v > MAX_W) v = MAX_W;
            return v;
        endfunction

        function int frame_rows();
            int v;
            v = int'(height_reg);
            if (v == 0) v = 1;
            else if (v > MAX_H) v = MAX_H;
            return v;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = data;
                REG_FRAME_HEIGHT: height_reg = data;
                REG_DO_DILATE:    dilate_reg = data[0];
                REG_FULL_SQUARE:  full_reg   = data[0];
                REG_BINARY_IMAGE: binary_reg = data[0];
                default: return;
            endcase
            restart();
        endfunction

        function logic [PIX_W-1:0] extreme(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
            if (dilate_reg) return (a > b) ? a : b;
            return (a < b) ? a : b;
        endfunction

        // combine the window around centre column cc; flags say which sides lie in the frame
        function logic [PIX_W-1:0] window_result(input int cc, input bit lok, input bit rok,
                                                 input bit tok, input bit bok);
            logic [PIX_W-1:0] pad, acc, up, dn, lf, rt, ul, dl, ur, dr;
            int lc, rc;
            lc  = cc - 1;
            rc  = (cc + 1) % 3;
            pad = dilate_reg ? PAD_DILATE : (binary_reg ? PAD_ERODE_BIN : PAD_ERODE);
            acc = win[cc][1];
            up  = tok ? win[cc][0] : pad;
            dn  = bok ? win[cc][2] : pad;
            lf  = lok ? win[lc][1] : pad;
            rt  = rok ? win[rc][1] : pad;
            acc = extreme(acc, extreme(extreme(lf, rt), extreme(up, dn)));
            if (full_reg) begin
                ul  = (lok && tok) ? win[lc][0] : pad;
                dl  = (lok && bok) ? win[lc][2] : pad;
                ur  = (rok && tok) ? win[rc][0] : pad;
                dr  = (rok && bok) ? win[rc][2] : pad;
                acc = extreme(acc, extreme(extreme(ul, dr), extreme(ur, dl)));
            end
            return acc;
        endfunction

        // one accepted input word: advance the model, queue the output it releases
        function void accept_word(input logic op, input logic [PIX_W-1:0] pix);
            int w, h, ic, r;
            bit in_frame, ready, emit;
            logic [PIX_W-1:0] cur, old_up, old_mid;
            frame_result_t res;
            w        = frame_cols();
            h        = frame_rows();
            in_frame = row_pos < h;
            // drain word while pixels are still due: no effect
            if (op == OP_DRAIN && in_frame) return;
            ic = (col_pos >= w) ? 0 : col_pos;
            cur     = in_frame ? pix : '0;
            old_up  = upper_line[ic];
            old_mid = middle_line[ic];
            upper_line[ic]  = old_mid;
            middle_line[ic] = cur;

            ready = (row_pos >= 2) || (row_pos == 1 && ic >= 1);
            emit  = ready && (out_pos < w * h);
            res.result_pixel = '0;
            res.frame_last   = 1'b0;

            // column 0: centre is the last column of the row two back
            if (emit && ic == 0) begin
                r = row_pos - 2;
                res.result_pixel = window_result(2, w >= 2, 1'b0, r >= 1, r + 1 < h);
            end

            for (int k = 0; k < 3; k++) begin
                win[0][k] = win[1][k];
                win[1][k] = win[2][k];
            end
            win[2][0] = old_up;
            win[2][1] = old_mid;
            win[2][2] = cur;

            if (emit && ic != 0) begin
                r = row_pos - 1;
                res.result_pixel = window_result(1, ic >= 2, 1'b1, r >= 1, r + 1 < h);
            end

            if (ic + 1 >= w) begin
                col_pos = 0;
                row_pos++;
            end else begin
                col_pos = ic + 1;
            end

            if (!emit) return;
            if (out_pos == w * h - 1) begin
                res.frame_last = 1'b1;
                restart();
            end else begin
                out_pos++;
            end
            expected_results.push_back(res);
        endfunction

        function void check_output(input logic [PIX_W-1:0] pix, input logic last);
            frame_result_t exp_res;
            if (expected_results.size() == 0) begin
                $error("output word with none expected: result_pixel %0d frame_last %0d",
                       pix, last);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (pix !== exp_res.result_pixel) begin
                $error("result_pixel mismatch: expected %0d, actual %0d",
                       exp_res.result_pixel, pix);
                errors++;
            end
            if (last !== exp_res.frame_last) begin
                $error("frame_last mismatch: expected %0d, actual %0d",
                       exp_res.frame_last, last);
                errors++;
            end
        endfunction

        function void report_leftover();
            if (expected_results.size() != 0) begin
                $error("%0d expected output words never arrived", expected_results.size());
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    wire logic          in_ready;
    logic               in_op     = OP_PIXEL;
    logic [PIX_W-1:0]   in_pix    = '0;
    wire logic          out_valid;
    logic               out_ready = 1'b0;
    wire logic [PIX_W-1:0] out_pix;
    wire logic          out_last;
    logic               cfg_valid = 1'b0;
    wire logic          cfg_ready;
    logic [CFG_IW-1:0]  cfg_index = '0;
    logic [CFG_DW-1:0]  cfg_data  = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_ticket   = 0;
    int hold_taken    = 0;
    int hold_left     = 0;

    morph_checker sb = new();

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    morphology_3x3_erode_dilate_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_opcode       (in_op),
        .i_pixel_value  (in_pix),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_result_pixel (out_pix),
        .o_frame_last   (out_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // output side: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            hold_taken <= 0;
            hold_left  <= 0;
        end else if (hold_taken != hold_ticket) begin
            hold_taken <= hold_ticket;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: every handshake on the three channels
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_output(out_pix, out_last);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready) sb.accept_word(in_op, in_pix);
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_word(input logic op, input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_pix   <= pix;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // stop sending and let every expected word come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int w, input int h, input logic [CFG_DW-1:0] dil,
                             input logic [CFG_DW-1:0] full, input logic [CFG_DW-1:0] bin);
        cfg_write(REG_FRAME_WIDTH, CFG_DW'(w));
        cfg_write(REG_FRAME_HEIGHT, CFG_DW'(h));
        cfg_write(REG_DO_DILATE, dil);
        cfg_write(REG_FULL_SQUARE, full);
        cfg_write(REG_BINARY_IMAGE, bin);
        cfg_valid <= 1'b0;
    endtask

    // mostly small frames; zero size now and then
    task automatic random_config();
        int sel, w, h;
        sel = $urandom_range(19);
        if (sel == 0) w = 0;
        else if (sel == 1) w = 1;
        else if (sel == 2) w = 2;
        else w = $urandom_range(16, 3);
        h = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
        configure(w, h, CFG_DW'($urandom_range(2047)), CFG_DW'($urandom_range(2047)),
                  CFG_DW'($urandom_range(2047)));
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    function automatic logic [PIX_W-1:0] style_pixel(input pixel_style_t style);
        case (style)
            STYLE_BINARY: return PIX_W'($urandom_range(1));
            STYLE_HOLES:  return ($urandom_range(7) == 0) ? 8'h00 : 8'hFF;
            STYLE_SPOTS:  return ($urandom_range(7) == 0) ? 8'hFF : 8'h00;
            default:      return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // one frame plus its drain words; stray drains inside, pixels among the tail
    task automatic run_frame(input pixel_style_t style, input int abort_at,
                             input int bogus_at, input int hold_at);
        int cols, total;
        cols  = sb.frame_cols();
        total = cols * sb.frame_rows();
        for (int i = 0; i < total; i++) begin
            if (i == abort_at) return;
            if (i == bogus_at) begin
                wait_idle();
                cfg_write(CFG_IW'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                          CFG_DW'($urandom_range(2047)));
                cfg_valid <= 1'b0;
            end
            if (i == hold_at) hold_ticket <= hold_ticket + 1;
            if ($urandom_range(24) == 0) send_word(OP_DRAIN, PIX_W'($urandom_range(255)));
            send_word(OP_PIXEL, style_pixel(style));
        end
        for (int i = 0; i <= cols; i++)
            send_word(($urandom_range(3) == 0) ? OP_PIXEL : OP_DRAIN,
                      PIX_W'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [PIX_W-1:0] edge_pix [9];
        int frame_no, items_done, total, cols, abort_at, bogus_at, hold_at, guard;
        bit must_reconfig;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idle(0, 0);

        // reset geometry: a drain while pixels are due is ignored
        send_word(OP_PIXEL, 8'hFF);
        send_word(OP_DRAIN, 8'h00);
        send_word(OP_PIXEL, 8'h00);
        wait_idle();

        // 3x3 erosion, cross window, extreme levels
        configure(3, 3, '0, '0, '0);
        edge_pix = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE};
        foreach (edge_pix[i]) begin
            send_word(OP_PIXEL, edge_pix[i]);
            if (i == 4) send_word(OP_DRAIN, 8'hFF);
        end
        send_word(OP_DRAIN, 8'h00);
        send_word(OP_PIXEL, 8'hFF);     // pixel after frame end counts as drain
        send_word(OP_DRAIN, 8'h00);
        send_word(OP_DRAIN, 8'h00);
        wait_idle();

        // zero width and height act as one: dilation, full window, binary
        configure(0, 0, 11'h001, 11'h001, 11'h001);
        send_word(OP_PIXEL, 8'h01);
        send_word(OP_DRAIN, 8'h00);
        send_word(OP_DRAIN, 8'h00);
        wait_idle();

        // binary erosion pads with one
        configure(2, 0, 11'h000, 11'h001, 11'h001);
        send_word(OP_PIXEL, 8'h01);
        send_word(OP_PIXEL, 8'h01);
        repeat (3) send_word(OP_DRAIN, 8'h00);

        // random frames, idle phases cycling frame by frame
        frame_no      = 0;
        items_done    = 0;
        must_reconfig = 1'b1;
        while (items_done < RANDOM_ITEMS) begin
            case (frame_no % 4)
                0: set_idle(0, 0);
                1: set_idle(79, 0);
                2: set_idle(0, 79);
                default: set_idle(17, 17);
            endcase
            if (must_reconfig || $urandom_range(3) != 0) begin
                wait_idle();
                random_config();
            end
            cols     = sb.frame_cols();
            total    = cols * sb.frame_rows();
            abort_at = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : -1;
            bogus_at = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : -1;
            hold_at  = ($urandom_range(19) == 0 && total > cols + 2) ? cols + 2 : -1;
            must_reconfig = (abort_at >= 0);
            run_frame(pixel_style_t'($urandom_range(3)), abort_at, bogus_at, hold_at);
            items_done += total + cols + 1;
            frame_no++;
        end

        // oversize width clamps to the store size
        set_idle(0, 0);
        wait_idle();
        configure($urandom_range(2047, 1025), 1, CFG_DW'($urandom_range(2047)),
                  CFG_DW'($urandom_range(2047)), CFG_DW'($urandom_range(2047)));
        run_frame(STYLE_UNIFORM, -1, -1, -1);

        // oversize height, with a long output hold-off so the input backs up
        wait_idle();
        configure(1, $urandom_range(2047, 1025), CFG_DW'($urandom_range(2047)),
                  CFG_DW'($urandom_range(2047)), CFG_DW'($urandom_range(2047)));
        run_frame(STYLE_UNIFORM, -1, -1, 10);

        // drain and report
        in_valid <= 1'b0;
        guard = 0;
        while (sb.outstanding() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.report_leftover();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard
    initial begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
